### rtl/hangul_glyph_index_composer_assert.svh
// assertion macros used by the checker file
// no dependencies
`ifndef HANGUL_GLYPH_INDEX_COMPOSER_ASSERT_SVH
`define HANGUL_GLYPH_INDEX_COMPOSER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define HGIC_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("hgic assertion failed");

// next-cycle implication, disabled while reset is low
`define HGIC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("hgic assertion failed");

`endif

### rtl/hgic_pkg.sv
// shared types, constants and shape tables for the hangul glyph composer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hgic_pkg;

    localparam int SCREEN_W_DEFAULT = 240;

    localparam logic [15:0] HANGUL_FIRST_CP = 16'hAC00;
    localparam logic [15:0] HANGUL_LAST_CP  = 16'hD7A3;
    localparam logic [7:0]  MEDIAL_BASE     = 8'd160;
    localparam logic [7:0]  FINAL_BASE      = 8'd248;

    // reciprocal constants for the two constant divisions
    localparam logic [11:0] RECIP_7       = 12'd2341;  // /7 with 14 bit shift
    localparam int          RECIP_7_SHIFT = 14;
    localparam logic [11:0] RECIP_21      = 12'd3121;  // /21 with 16 bit shift
    localparam int          RECIP_21_SHIFT = 16;

    typedef enum logic [1:0] {
        KIND_ASCII   = 2'd0,
        KIND_HANGUL  = 2'd1,
        KIND_INVALID = 2'd2
    } glyph_kind_t;

    // continuation bytes still expected
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_LAST = 2'd1,
        PEND_MID  = 2'd2
    } pend_t;

    localparam logic [2:0] INIT_TYPE_OPEN [22] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3,
        3'd3, 3'd3, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0
    };

    localparam logic [2:0] INIT_TYPE_CLOSED [22] = '{
        3'd0, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd7,
        3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd5
    };

    localparam logic [1:0] FIN_TYPE [22] = '{
        2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0,
        2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1
    };

endpackage

`default_nettype wire

### rtl/hgic_byte_if.sv
// valid/ready channel carrying one text byte and its string controls
// depends on hgic_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hgic_byte_if;
    import hgic_pkg::*;

    logic        valid;
    logic        ready;
    logic [7:0]  text_byte;
    logic        starts_string;
    logic [10:0] start_x;
    logic [15:0] start_y;
    logic [3:0]  scale;

    modport source (
        output valid, text_byte, starts_string, start_x, start_y, scale,
        input  ready
    );

    modport sink (
        input  valid, text_byte, starts_string, start_x, start_y, scale,
        output ready
    );
endinterface

`default_nettype wire

### rtl/hgic_glyph_if.sv
// valid/ready channel carrying one glyph record
// depends on hgic_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hgic_glyph_if;
    import hgic_pkg::*;

    logic        valid;
    logic        ready;
    glyph_kind_t glyph_kind;
    logic [6:0]  ascii_code;
    logic [7:0]  initial_index;
    logic [8:0]  medial_index;
    logic [8:0]  final_index;
    logic        has_final;
    logic [10:0] glyph_x;
    logic [15:0] glyph_y;
    logic [3:0]  glyph_scale;
    logic [15:0] text_length;

    modport source (
        output valid, glyph_kind, ascii_code, initial_index, medial_index,
               final_index, has_final, glyph_x, glyph_y, glyph_scale, text_length,
        input  ready
    );

    modport sink (
        input  valid, glyph_kind, ascii_code, initial_index, medial_index,
               final_index, has_final, glyph_x, glyph_y, glyph_scale, text_length,
        output ready
    );
endinterface

`default_nettype wire

### rtl/hangul_glyph_index_composer.sv
// Hangul glyph index composer: takes one UTF-8 text byte per cycle on text_in and
// delivers one glyph record on glyph_out for every ASCII byte and every completed
// three-byte group (lead bytes and the first continuation give no record). A byte is
// accepted every cycle while the output side takes results; a record passes through
// one staging register and then the result register before it appears on glyph_out.
// The cursor and length update closes in the cycle the byte is accepted.
// No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module hangul_glyph_index_composer #(
    parameter int SCREEN_W = hgic_pkg::SCREEN_W_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    hgic_byte_if.sink     text_in,
    hgic_glyph_if.source  glyph_out
);
    import hgic_pkg::*;

    localparam logic [12:0] ScreenW = 13'(SCREEN_W);

    // string state
    logic [10:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic [3:0]  held_scale_reg, held_scale_next;
    pend_t       pend_reg, pend_next;
    logic [3:0]  lead_reg, lead_next;
    logic [5:0]  middle_reg, middle_next;
    logic [15:0] length_reg, length_next;

    // staging register
    logic        s1_valid_reg;
    glyph_kind_t s1_kind_reg;
    logic [6:0]  s1_ascii_reg;
    logic [10:0] s1_x_reg;
    logic [15:0] s1_y_reg;
    logic [3:0]  s1_scale_reg;
    logic [15:0] s1_length_reg;
    logic [13:0] s1_offset_reg;
    logic [8:0]  s1_quot_reg;

    // result register
    logic        out_valid_reg;
    glyph_kind_t out_kind_reg;
    logic [6:0]  out_ascii_reg;
    logic [7:0]  out_init_reg;
    logic [8:0]  out_med_reg;
    logic [8:0]  out_fin_reg;
    logic        out_hasf_reg;
    logic [10:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic [3:0]  out_scale_reg;
    logic [15:0] out_length_reg;

    logic        advance;
    logic        accept;
    logic [10:0] eff_x;
    logic [15:0] eff_y;
    logic [3:0]  eff_scale;
    pend_t       eff_pend;
    logic [15:0] eff_length;
    logic        emit;
    glyph_kind_t kind;
    logic [7:0]  width;
    logic [16:0] len_sum;
    logic [11:0] nx;
    logic [12:0] nx_far;
    logic [15:0] cp;
    logic        cp_ok;
    logic [13:0] offset;
    logic [23:0] quot_prod;
    logic [7:0]  map_init;
    logic [8:0]  map_med;
    logic [8:0]  map_fin;
    logic        map_hasf;

    assign advance       = !out_valid_reg || glyph_out.ready;
    assign accept        = text_in.valid && advance;
    assign text_in.ready = advance;

    // values in force for this byte once a string start is applied
    always_comb
    begin
        eff_x      = text_in.starts_string ? text_in.start_x : cursor_x_reg;
        eff_y      = text_in.starts_string ? text_in.start_y : cursor_y_reg;
        eff_scale  = text_in.starts_string ? text_in.scale   : held_scale_reg;
        eff_pend   = text_in.starts_string ? PEND_NONE       : pend_reg;
        eff_length = text_in.starts_string ? 16'd0           : length_reg;
    end

    // pending-byte next state
    always_comb
    begin
        case (eff_pend)
            PEND_MID:  pend_next = PEND_LAST;
            PEND_LAST: pend_next = PEND_NONE;
            PEND_NONE: pend_next = text_in.text_byte[7] ? PEND_MID : PEND_NONE;
            default:   pend_next = PEND_NONE;
        endcase
    end

    // glyph classification and cursor advance
    always_comb
    begin
        cp     = {lead_reg, middle_reg, text_in.text_byte[5:0]};
        cp_ok  = (cp >= HANGUL_FIRST_CP) && (cp <= HANGUL_LAST_CP);
        offset = 14'(cp - HANGUL_FIRST_CP);

        quot_prod = 24'(offset[13:2]) * 24'(RECIP_7);

        case (eff_pend)
            PEND_LAST:
            begin
                emit = 1'b1;
                kind = cp_ok ? KIND_HANGUL : KIND_INVALID;
            end
            PEND_NONE:
            begin
                emit = !text_in.text_byte[7];
                kind = KIND_ASCII;
            end
            default:
            begin
                emit = 1'b0;
                kind = KIND_ASCII;
            end
        endcase

        width   = (kind == KIND_ASCII) ? {1'b0, eff_scale, 3'b000} : {eff_scale, 4'b0000};
        len_sum = 17'(eff_length) + 17'(width);
        nx      = 12'(eff_x) + 12'(width);
        // nx > screen - width, kept unsigned
        nx_far  = 13'(nx) + 13'(width);

        lead_next   = lead_reg;
        middle_next = middle_reg;
        if (eff_pend == PEND_MID)
            middle_next = text_in.text_byte[5:0];
        else if (eff_pend == PEND_NONE && text_in.text_byte[7])
            lead_next = text_in.text_byte[3:0];

        held_scale_next = eff_scale;
        if (emit)
        begin
            length_next = len_sum[16] ? 16'hFFFF : len_sum[15:0];
            if (nx_far > ScreenW)
            begin
                cursor_x_next = 11'd0;
                cursor_y_next = eff_y + 16'({eff_scale, 4'b0000});
            end
            else
            begin
                cursor_x_next = nx[10:0];
                cursor_y_next = eff_y;
            end
        end
        else
        begin
            length_next   = eff_length;
            cursor_x_next = eff_x;
            cursor_y_next = eff_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            held_scale_reg <= '0;
            pend_reg       <= PEND_NONE;
            lead_reg       <= '0;
            middle_reg     <= '0;
            length_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cursor_x_reg   <= cursor_x_next;
                cursor_y_reg   <= cursor_y_next;
                held_scale_reg <= held_scale_next;
                pend_reg       <= pend_next;
                lead_reg       <= lead_next;
                middle_reg     <= middle_next;
                length_reg     <= length_next;
            end
            if (advance)
            begin
                s1_valid_reg  <= accept && emit;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg    <= kind;
            s1_ascii_reg   <= (kind == KIND_ASCII) ? text_in.text_byte[6:0] : 7'd0;
            s1_x_reg       <= eff_x;
            s1_y_reg       <= eff_y;
            s1_scale_reg   <= eff_scale;
            s1_length_reg  <= length_next;
            s1_offset_reg  <= offset;
            s1_quot_reg    <= 9'(quot_prod >> RECIP_7_SHIFT);

            out_kind_reg   <= s1_kind_reg;
            out_ascii_reg  <= s1_ascii_reg;
            out_init_reg   <= (s1_kind_reg == KIND_HANGUL) ? map_init : 8'd0;
            out_med_reg    <= (s1_kind_reg == KIND_HANGUL) ? map_med  : 9'd0;
            out_fin_reg    <= (s1_kind_reg == KIND_HANGUL) ? map_fin  : 9'd0;
            out_hasf_reg   <= (s1_kind_reg == KIND_HANGUL) && map_hasf;
            out_x_reg      <= s1_x_reg;
            out_y_reg      <= s1_y_reg;
            out_scale_reg  <= s1_scale_reg;
            out_length_reg <= s1_length_reg;
        end
    end

    hgic_jamo_map u_jamo_map (
        .syl_offset    (s1_offset_reg),
        .syl_quot      (s1_quot_reg),
        .initial_index (map_init),
        .medial_index  (map_med),
        .final_index   (map_fin),
        .has_final     (map_hasf)
    );

    assign glyph_out.valid         = out_valid_reg;
    assign glyph_out.glyph_kind    = out_kind_reg;
    assign glyph_out.ascii_code    = out_ascii_reg;
    assign glyph_out.initial_index = out_init_reg;
    assign glyph_out.medial_index  = out_med_reg;
    assign glyph_out.final_index   = out_fin_reg;
    assign glyph_out.has_final     = out_hasf_reg;
    assign glyph_out.glyph_x       = out_x_reg;
    assign glyph_out.glyph_y       = out_y_reg;
    assign glyph_out.glyph_scale   = out_scale_reg;
    assign glyph_out.text_length   = out_length_reg;
endmodule

`default_nettype wire

### rtl/hgic_jamo_map.sv
// splits a syllable offset into jamo and maps them to font row indices
// depends on hgic_pkg
`timescale 1ns / 1ps
`default_nettype none

module hgic_jamo_map (
    input  wire logic [13:0] syl_offset,   // code point minus first syllable
    input  wire logic [8:0]  syl_quot,     // syl_offset / 28
    output logic      [7:0]  initial_index,
    output logic      [8:0]  medial_index,
    output logic      [8:0]  final_index,
    output logic             has_final
);
    import hgic_pkg::*;

    logic [13:0] prod28;
    logic [4:0]  last;
    logic [20:0] q21_prod;
    logic [4:0]  q21;
    logic [8:0]  prod21;
    logic [4:0]  mid;
    logic [4:0]  first;
    logic        plain;
    logic [2:0]  ftype;
    logic [1:0]  mtype;
    logic [1:0]  fin_t;

    always_comb
    begin
        // remainder mod 28 from the quotient
        prod28   = {syl_quot, 5'b00000} - {3'b000, syl_quot, 2'b00};
        last     = 5'(syl_offset - prod28);

        q21_prod = 21'(syl_quot) * 21'(RECIP_21);
        q21      = 5'(q21_prod >> RECIP_21_SHIFT);
        prod21   = 9'({q21, 4'b0000}) + 9'({q21, 2'b00}) + 9'(q21);
        mid      = 5'(syl_quot - prod21) + 5'd1;
        first    = q21 + 5'd1;

        // initials g and k take the plain vowel shapes
        plain    = (q21 == 5'd0) || (q21 == 5'd15);
        fin_t    = FIN_TYPE[mid];

        if (last == 5'd0)
        begin
            ftype = INIT_TYPE_OPEN[mid];
            mtype = plain ? 2'd0 : 2'd1;
        end
        else
        begin
            ftype = INIT_TYPE_CLOSED[mid];
            mtype = plain ? 2'd2 : 2'd3;
        end

        initial_index = {1'b0, ftype, 4'b0000} + {3'b000, ftype, 2'b00} + {3'b000, first};
        medial_index  = 9'(MEDIAL_BASE) + 9'({mtype, 4'b0000}) + 9'({mtype, 2'b00})
                      + 9'({mtype, 1'b0}) + 9'(mid);
        has_final     = (last != 5'd0);
        final_index   = has_final
                      ? 9'(FINAL_BASE) + 9'({fin_t, 5'b00000}) - 9'({fin_t, 2'b00}) + 9'(last)
                      : 9'd0;
    end
endmodule

`default_nettype wire

### rtl/hgic_checker.sv
// port-level checks for the glyph composer and the bind that attaches them
// depends on hgic_pkg and hangul_glyph_index_composer_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "hangul_glyph_index_composer_assert.svh"

module hgic_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire hgic_pkg::glyph_kind_t out_kind,
    input wire logic [6:0]          out_ascii,
    input wire logic [7:0]          out_init,
    input wire logic [8:0]          out_med,
    input wire logic [8:0]          out_fin,
    input wire logic                out_hasf,
    input wire logic [10:0]         out_x,
    input wire logic [15:0]         out_y,
    input wire logic [15:0]         out_length
);
    import hgic_pkg::*;

    // a stalled item holds
    `HGIC_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_kind) && $stable(out_x) && $stable(out_y)
        && $stable(out_length) && $stable(out_init) && $stable(out_fin))

    // only syllables carry jamo rows, only ascii carries a code
    `HGIC_ASSERT_IMPL(a_non_hangul_zero, clk, rst_n,
        out_valid && out_kind != KIND_HANGUL,
        out_init == 8'd0 && out_med == 9'd0 && out_fin == 9'd0 && !out_hasf
        && (out_kind == KIND_ASCII || out_ascii == 7'd0))

    // final row present exactly when the syllable has a final
    `HGIC_ASSERT_IMPL(a_final_flag, clk, rst_n, out_valid,
        out_hasf == (out_fin != 9'd0))

    // vowel rows sit in their own region of the font
    `HGIC_ASSERT_IMPL(a_medial_range, clk, rst_n,
        out_valid && out_kind == KIND_HANGUL,
        out_med >= 9'd160 && out_med <= 9'd359 && out_init <= 8'd159)
endmodule

bind hangul_glyph_index_composer hgic_checker u_hgic_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (glyph_out.valid),
    .out_ready  (glyph_out.ready),
    .out_kind   (glyph_out.glyph_kind),
    .out_ascii  (glyph_out.ascii_code),
    .out_init   (glyph_out.initial_index),
    .out_med    (glyph_out.medial_index),
    .out_fin    (glyph_out.final_index),
    .out_hasf   (glyph_out.has_final),
    .out_x      (glyph_out.glyph_x),
    .out_y      (glyph_out.glyph_y),
    .out_length (glyph_out.text_length)
);

`default_nettype wire
